/* design/qpgs_pkg.sv */
// shared types and constants for the queue proportional green split block
package qpgs_pkg;

   // field widths
   localparam int QUEUE_W = 16;
   localparam int LANE_W  = 5;
   localparam int GREEN_W = 18;
   localparam int CT_W    = 10;

   // cycle time is whole seconds, results are in 1/256 s
   localparam int FRAC_W = 8;

   // extra pool times queue length
   localparam int PROD_W = GREEN_W + QUEUE_W;

   // base pool is one fifth of the cycle
   localparam int BASE_SHARE_DIV = 5;

   // register reset and default capacity
   localparam logic [CT_W-1:0] CT_RESET = CT_W'(120);
   localparam int DEFAULT_MAX_LANES = 32;

   // input transaction
   typedef struct packed {
      logic [QUEUE_W-1:0] queue_length;
      logic               last_lane;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [LANE_W-1:0]  lane_index;
      logic [GREEN_W-1:0] base_green;
      logic [GREEN_W-1:0] green_time;
      logic               last_result;
      logic               overflow;
   } rsp_type;

endpackage

/* design/queue_proportional_green_split.sv */
// a lane transaction is taken whenever the sequencer is in S_LOAD; after the last lane
// the divisions run, then the n stored lanes are emitted.
// one lane set at a time; a shared 18-step restoring divider (one quotient bit per
// cycle) sets the pace: twice per set and once per lane, or once for all-zero queues.
// reset: synchronous, clears the sequencer, set state and output valid, loads
// cycle_time with 120; the queue and green memories are not cleared.
module queue_proportional_green_split #(
   parameter int MAX_LANES = qpgs_pkg::DEFAULT_MAX_LANES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  qpgs_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output qpgs_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [qpgs_pkg::CT_W-1:0]    csr_wr_data
);

   import qpgs_pkg::*;

   localparam int IDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int CNT_W = $clog2(MAX_LANES + 1);
   localparam int TOT_W = QUEUE_W + CNT_W;
   localparam int QUO_W = GREEN_W;
   localparam int STEP_W = $clog2(QUO_W);

   // sequencer codes
   localparam logic [3:0] S_LOAD      = 4'd0;
   localparam logic [3:0] S_POOL_GO   = 4'd1;
   localparam logic [3:0] S_POOL_WAIT = 4'd2;
   localparam logic [3:0] S_BASE_GO   = 4'd3;
   localparam logic [3:0] S_BASE_WAIT = 4'd4;
   localparam logic [3:0] S_LANE_RD   = 4'd5;
   localparam logic [3:0] S_LANE_MUL  = 4'd6;
   localparam logic [3:0] S_LANE_GO   = 4'd7;
   localparam logic [3:0] S_LANE_WAIT = 4'd8;
   localparam logic [3:0] S_LEFT      = 4'd9;
   localparam logic [3:0] S_EMIT_RD   = 4'd10;
   localparam logic [3:0] S_EMIT_PUT  = 4'd11;

   // control state
   logic [3:0]          state_ff, state_in;
   logic [CT_W-1:0]     cycle_time_ff, cycle_time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [IDX_W-1:0]    heavy_idx_ff, heavy_idx_in;
   logic [QUEUE_W-1:0]  heavy_q_ff, heavy_q_in;
   logic                lost_ff, lost_in;
   logic [IDX_W-1:0]    lane_ff, lane_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [GREEN_W-1:0]  pool_ff, pool_in;
   logic [GREEN_W-1:0]  extra_ff, extra_in;
   logic [GREEN_W-1:0]  base_ff, base_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [GREEN_W:0]    sum_ff, sum_in;
   logic [GREEN_W-1:0]  leftover_ff, leftover_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // shared divider registers
   logic                div_busy_ff, div_busy_in;
   logic [STEP_W-1:0]   div_step_ff, div_step_in;
   logic [TOT_W-1:0]    div_rem_ff, div_rem_in;
   logic [QUO_W-1:0]    div_quo_ff, div_quo_in;
   logic [TOT_W-1:0]    div_dsr_ff, div_dsr_in;

   // divider launch request from the sequencer
   logic                div_go;
   logic [PROD_W-1:0]   div_dvd;
   logic [TOT_W-1:0]    div_dsr;

   // memory ports
   logic                q_wr_en;
   logic [QUEUE_W-1:0]  q_rd_data;
   logic                g_wr_en;
   logic [GREEN_W-1:0]  g_wr_data;
   logic [GREEN_W-1:0]  g_rd_data;

   // misc
   logic                req_accept;
   logic                rsp_take;
   logic [GREEN_W-1:0]  cycle_units;
   logic                total_zero;
   logic                lane_last;
   logic                store_room;
   logic [TOT_W:0]      div_trial;
   logic                div_bit;
   logic [GREEN_W-1:0]  emit_green;

   assign req_accept  = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign req_stall   = (state_ff != S_LOAD);
   assign cycle_units = {cycle_time_ff, {FRAC_W{1'b0}}};
   assign total_zero  = (total_ff == '0);
   assign lane_last   = (CNT_W'(CNT_W'(lane_ff) + 1'b1) == count_ff);
   assign store_room  = (count_ff < CNT_W'(MAX_LANES));

   // queue store and per-lane green store
   assign q_wr_en = req_accept && store_room;

   qpgs_ram #(
      .DATA_W (QUEUE_W),
      .DEPTH  (MAX_LANES)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (req_data.queue_length),
      .rd_addr (lane_ff),
      .rd_data (q_rd_data)
   );

   qpgs_ram #(
      .DATA_W (GREEN_W),
      .DEPTH  (MAX_LANES)
   ) u_green_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (lane_ff),
      .wr_data (g_wr_data),
      .rd_addr (lane_ff),
      .rd_data (g_rd_data)
   );

   // restoring divider step, one quotient bit per cycle
   always_comb begin
      div_trial   = {div_rem_ff, div_quo_ff[QUO_W-1]};
      div_bit     = (div_trial >= {1'b0, div_dsr_ff});
      div_busy_in = div_busy_ff;
      div_step_in = div_step_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_dsr_in  = div_dsr_ff;
      if (div_go) begin
         // upper dividend bits are known to sit below the divisor
         div_rem_in  = TOT_W'(div_dvd[PROD_W-1:QUO_W]);
         div_quo_in  = div_dvd[QUO_W-1:0];
         div_dsr_in  = div_dsr;
         div_step_in = '0;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         if (div_bit) begin
            div_rem_in = TOT_W'(div_trial - {1'b0, div_dsr_ff});
         end else begin
            div_rem_in = div_trial[TOT_W-1:0];
         end
         div_quo_in  = {div_quo_ff[QUO_W-2:0], div_bit};
         div_step_in = STEP_W'(div_step_ff + 1'b1);
         if (div_step_ff == STEP_W'(QUO_W - 1)) begin
            div_busy_in = 1'b0;
         end
      end
   end

   // green for the lane being emitted, leftover lands on the heaviest lane
   always_comb begin
      if (total_zero) begin
         emit_green = base_ff;
      end else if (lane_ff == heavy_idx_ff && heavy_q_ff != '0) begin
         emit_green = GREEN_W'(g_rd_data + leftover_ff);
      end else begin
         emit_green = g_rd_data;
      end
   end

   // sequencer and set bookkeeping
   always_comb begin
      state_in      = state_ff;
      cycle_time_in = cycle_time_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      heavy_idx_in  = heavy_idx_ff;
      heavy_q_in    = heavy_q_ff;
      lost_in       = lost_ff;
      lane_in       = lane_ff;
      rsp_valid_in  = rsp_valid_ff;
      pool_in       = pool_ff;
      extra_in      = extra_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      leftover_in   = leftover_ff;
      rsp_data_in   = rsp_data_ff;
      div_go        = 1'b0;
      div_dvd       = '0;
      div_dsr       = '0;
      g_wr_en       = 1'b0;
      g_wr_data     = GREEN_W'(base_ff + div_quo_ff);

      if (csr_wr_en) begin
         cycle_time_in = csr_wr_data;
      end

      // output register drains independently of the sequencer
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (store_room) begin
                  total_in = TOT_W'(total_ff + req_data.queue_length);
                  if (req_data.queue_length > heavy_q_ff) begin
                     heavy_q_in   = req_data.queue_length;
                     heavy_idx_in = IDX_W'(count_ff);
                  end
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  lost_in = 1'b1;
               end
               if (req_data.last_lane) begin
                  state_in = S_POOL_GO;
               end
            end
         end
         S_POOL_GO: begin
            // all-zero queues share the whole cycle evenly
            div_go   = 1'b1;
            div_dvd  = PROD_W'(cycle_units);
            div_dsr  = total_zero ? TOT_W'(count_ff) : TOT_W'(BASE_SHARE_DIV);
            state_in = S_POOL_WAIT;
         end
         S_POOL_WAIT: begin
            if (!div_busy_ff) begin
               lane_in = '0;
               if (total_zero) begin
                  base_in  = div_quo_ff;
                  state_in = S_EMIT_RD;
               end else begin
                  pool_in  = div_quo_ff;
                  extra_in = GREEN_W'(cycle_units - div_quo_ff);
                  state_in = S_BASE_GO;
               end
            end
         end
         S_BASE_GO: begin
            div_go   = 1'b1;
            div_dvd  = PROD_W'(pool_ff);
            div_dsr  = TOT_W'(count_ff);
            state_in = S_BASE_WAIT;
         end
         S_BASE_WAIT: begin
            if (!div_busy_ff) begin
               base_in  = div_quo_ff;
               sum_in   = '0;
               lane_in  = '0;
               state_in = S_LANE_RD;
            end
         end
         S_LANE_RD: begin
            state_in = S_LANE_MUL;
         end
         S_LANE_MUL: begin
            prod_in  = PROD_W'(extra_ff) * PROD_W'(q_rd_data);
            state_in = S_LANE_GO;
         end
         S_LANE_GO: begin
            div_go   = 1'b1;
            div_dvd  = prod_ff;
            div_dsr  = total_ff;
            state_in = S_LANE_WAIT;
         end
         S_LANE_WAIT: begin
            if (!div_busy_ff) begin
               g_wr_en = 1'b1;
               sum_in  = (GREEN_W+1)'(sum_ff + g_wr_data);
               if (lane_last) begin
                  lane_in  = '0;
                  state_in = S_LEFT;
               end else begin
                  lane_in  = IDX_W'(lane_ff + 1'b1);
                  state_in = S_LANE_RD;
               end
            end
         end
         S_LEFT: begin
            if (sum_ff < {1'b0, cycle_units}) begin
               leftover_in = GREEN_W'({1'b0, cycle_units} - sum_ff);
            end else begin
               leftover_in = '0;
            end
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_PUT;
         end
         S_EMIT_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.lane_index  = LANE_W'(lane_ff);
               rsp_data_in.base_green  = base_ff;
               rsp_data_in.green_time  = emit_green;
               rsp_data_in.last_result = lane_last;
               rsp_data_in.overflow    = lost_ff;
               if (lane_last) begin
                  // set finished, back to loading
                  count_in     = '0;
                  total_in     = '0;
                  heavy_idx_in = '0;
                  heavy_q_in   = '0;
                  lost_in      = 1'b0;
                  lane_in      = '0;
                  state_in     = S_LOAD;
               end else begin
                  lane_in  = IDX_W'(lane_ff + 1'b1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         cycle_time_ff <= CT_RESET;
         count_ff      <= '0;
         total_ff      <= '0;
         heavy_idx_ff  <= '0;
         heavy_q_ff    <= '0;
         lost_ff       <= 1'b0;
         lane_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         div_busy_ff   <= 1'b0;
         div_step_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         cycle_time_ff <= cycle_time_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         heavy_idx_ff  <= heavy_idx_in;
         heavy_q_ff    <= heavy_q_in;
         lost_ff       <= lost_in;
         lane_ff       <= lane_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_busy_ff   <= div_busy_in;
         div_step_ff   <= div_step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pool_ff     <= pool_in;
      extra_ff    <= extra_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      leftover_ff <= leftover_in;
      rsp_data_ff <= rsp_data_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dsr_ff  <= div_dsr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (state_ff == S_POOL_WAIT || state_ff == S_BASE_WAIT ||
                       state_ff == S_LANE_WAIT))
      else $error("divider busy outside a wait state");

   // partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (div_rem_ff < div_dsr_ff))
      else $error("divider remainder not below divisor");

   // stored lane count never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LANES))
      else $error("lane count beyond capacity");

   // heaviest lane points at a stored lane
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (CNT_W'(heavy_idx_ff) < count_ff))
      else $error("heaviest lane index outside stored set");

   // a new result is only loaded from the emit state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT_PUT))
      else $error("result valid raised outside emit");
`endif

endmodule

/* design/qpgs_ram.sv */
// generic single write port, single read port ram with registered read
module qpgs_ram #(
   parameter int DATA_W = qpgs_pkg::QUEUE_W,
   parameter int DEPTH  = qpgs_pkg::DEFAULT_MAX_LANES
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                     rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
